// File: rtl/fepg_pkg.sv
// ----------------------------------------------------------------------------
// fepg_pkg: filled ellipse pixel generator package
// Shared constants, register indexes and control types.
// ----------------------------------------------------------------------------
`default_nettype none

package fepg_pkg;

  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int COLOR_W     = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_LEFT   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TOP    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RIGHT  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BOTTOM = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_FILL   = 3'd4;

  localparam int LEFT_RESET   = 0;
  localparam int TOP_RESET    = 0;
  localparam int RIGHT_RESET  = 479;
  localparam int BOTTOM_RESET = 271;

  localparam logic [COLOR_W-1:0] FILL_RESET = 16'h0000;
  localparam logic [COLOR_W-1:0] BACKGROUND = 16'hFFFF;

  typedef struct packed {
    logic load_pos;
    logic load_sq;
    logic load_prod;
    logic load_out;
  } fepg_cmd_t;

  typedef struct packed {
    logic empty;
  } fepg_status_t;

endpackage

`default_nettype wire

// File: rtl/fepg_req_if.sv
// ----------------------------------------------------------------------------
// fepg_req_if: request channel
// Valid/ready channel carrying the scan restart flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface fepg_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

`default_nettype wire

// File: rtl/fepg_pix_if.sv
// ----------------------------------------------------------------------------
// fepg_pix_if: pixel channel
// Valid/ready channel carrying one pixel with its coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

interface fepg_pix_if
  import fepg_pkg::*;
#(
  parameter int COORD_BITS = 10
);
  logic                  valid;
  logic                  ready;
  logic [COLOR_W-1:0]    pixel_value;
  logic [COORD_BITS-1:0] pixel_column;
  logic [COORD_BITS-1:0] pixel_row;
  logic                  frame_last;

  modport source (output valid, output pixel_value, output pixel_column,
                  output pixel_row, output frame_last, input ready);
  modport sink   (input valid, input pixel_value, input pixel_column,
                  input pixel_row, input frame_last, output ready);
endinterface

`default_nettype wire

// File: rtl/filled_ellipse_pixel_generator.sv
// ----------------------------------------------------------------------------
// filled_ellipse_pixel_generator: filled ellipse rasterizer
// Scans the configured rectangle in raster order, one pixel per request,
// coloring pixels strictly inside the inscribed ellipse.
//
//   Channel  Dir  Payload
//   req      in   restart
//   pix      out  pixel_value, pixel_column, pixel_row, frame_last
//   cfg      in   cfg_index, cfg_data (write only)
//
// A request steps through position select, squares, cross products, then
// the compare into the output register; the sequencer takes the next request
// only once the output register is loaded, never while one is in flight.
// A request on an empty rectangle is accepted and yields no pixel.
// Synchronous reset restores the rectangle, fill color and scan corner.
// A stalled pixel holds in the output register; the next result waits in
// the compare stage until it frees.
// ----------------------------------------------------------------------------
`default_nettype none

module filled_ellipse_pixel_generator
  import fepg_pkg::*;
#(
  parameter int COORD_BITS = 10
)(
  input  wire logic                   clk,
  input  wire logic                   rst,
  fepg_req_if.sink                    req,
  fepg_pix_if.source                  pix,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  fepg_cmd_t             cmd;
  fepg_status_t          status;
  logic                  in_ready;
  logic                  out_valid;
  logic [COLOR_W-1:0]    pixel_value;
  logic [COORD_BITS-1:0] pixel_column;
  logic [COORD_BITS-1:0] pixel_row;
  logic                  frame_last;

  fepg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (pix.ready),
    .status    (status),
    .cmd       (cmd)
  );

  fepg_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .restart      (req.restart),
    .cmd          (cmd),
    .status       (status),
    .pixel_value  (pixel_value),
    .pixel_column (pixel_column),
    .pixel_row    (pixel_row),
    .frame_last   (frame_last)
  );

  assign req.ready        = in_ready;
  assign pix.valid        = out_valid;
  assign pix.pixel_value  = pixel_value;
  assign pix.pixel_column = pixel_column;
  assign pix.pixel_row    = pixel_row;
  assign pix.frame_last   = frame_last;

endmodule

`default_nettype wire

// File: rtl/fepg_ctrl.sv
// ----------------------------------------------------------------------------
// fepg_ctrl: sequencing controller
// Steps one request through position, square, product and output stages.
// ----------------------------------------------------------------------------
`default_nettype none

module fepg_ctrl
  import fepg_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  wire logic         out_ready,
  input  wire fepg_status_t status,
  output fepg_cmd_t         cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SQ   = 4'b0010,
    ST_PROD = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && !status.empty) begin
          cmd.load_pos = 1'b1;
          state_next   = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd.load_sq = 1'b1;
        state_next  = ST_PROD;
      end
      ST_PROD: begin
        cmd.load_prod = 1'b1;
        state_next    = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/fepg_dp.sv
// ----------------------------------------------------------------------------
// fepg_dp: datapath
// Holds the rectangle registers and scan position, and evaluates the
// ellipse test over three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module fepg_dp
  import fepg_pkg::*;
#(
  parameter int COORD_BITS = 10
)(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   restart,
  input  wire fepg_cmd_t              cmd,
  output fepg_status_t                status,
  output logic [COLOR_W-1:0]          pixel_value,
  output logic [COORD_BITS-1:0]       pixel_column,
  output logic [COORD_BITS-1:0]       pixel_row,
  output logic                        frame_last
);

  localparam int CW   = COORD_BITS;
  localparam int HW   = COORD_BITS - 1;
  localparam int SQW  = 2 * CW;
  localparam int HSQW = 2 * HW;
  localparam int PW   = SQW + HSQW;
  localparam int ABW  = 2 * HSQW;
  localparam int SUMW = PW + 1;

  logic [CW-1:0]      left_column;
  logic [CW-1:0]      top_row;
  logic [CW-1:0]      right_column;
  logic [CW-1:0]      bottom_row;
  logic [COLOR_W-1:0] fill_color;

  logic [CW-1:0] scan_column;
  logic [CW-1:0] scan_row;
  logic [CW-1:0] scan_column_next;
  logic [CW-1:0] scan_row_next;

  logic          outside;
  logic [CW-1:0] col;
  logic [CW-1:0] row;
  logic          last_col;
  logic          last_row;
  logic [CW:0]   mid_x;
  logic [CW:0]   mid_y;
  logic [CW-1:0] cx;
  logic [CW-1:0] cy;
  logic [CW-1:0] span_x;
  logic [CW-1:0] span_y;

  logic [CW-1:0]   cur_col;
  logic [CW-1:0]   cur_row;
  logic            cur_last;
  logic            degen;
  logic [CW-1:0]   dx;
  logic [CW-1:0]   dy;
  logic [HW-1:0]   ha;
  logic [HW-1:0]   hb;
  logic [SQW-1:0]  dx2;
  logic [SQW-1:0]  dy2;
  logic [HSQW-1:0] a2;
  logic [HSQW-1:0] b2;
  logic [PW-1:0]   px;
  logic [PW-1:0]   py;
  logic [ABW-1:0]  ab;
  logic [SUMW-1:0] ell_sum;
  logic            in_ell;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_column  <= CW'(LEFT_RESET);
      top_row      <= CW'(TOP_RESET);
      right_column <= CW'(RIGHT_RESET);
      bottom_row   <= CW'(BOTTOM_RESET);
      fill_color   <= FILL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEFT:   left_column  <= cfg_data[CW-1:0];
        REG_TOP:    top_row      <= cfg_data[CW-1:0];
        REG_RIGHT:  right_column <= cfg_data[CW-1:0];
        REG_BOTTOM: bottom_row   <= cfg_data[CW-1:0];
        REG_FILL:   fill_color   <= cfg_data[COLOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign status.empty = (right_column < left_column) || (bottom_row < top_row);

  always_comb begin
    outside = (scan_column < left_column) || (scan_column > right_column) ||
              (scan_row < top_row) || (scan_row > bottom_row);
    col      = (restart || outside) ? left_column : scan_column;
    row      = (restart || outside) ? top_row : scan_row;
    last_col = (col == right_column);
    last_row = (row == bottom_row);
    if (!last_col) begin
      scan_column_next = col + CW'(1);
      scan_row_next    = row;
    end else begin
      scan_column_next = left_column;
      scan_row_next    = last_row ? top_row : row + CW'(1);
    end
    mid_x  = (CW+1)'(left_column) + (CW+1)'(right_column);
    mid_y  = (CW+1)'(top_row) + (CW+1)'(bottom_row);
    cx     = mid_x[CW:1];
    cy     = mid_y[CW:1];
    span_x = right_column - left_column;
    span_y = bottom_row - top_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_column <= CW'(LEFT_RESET);
      scan_row    <= CW'(TOP_RESET);
    end else if (cmd.load_pos) begin
      scan_column <= scan_column_next;
      scan_row    <= scan_row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pos) begin
      cur_col  <= col;
      cur_row  <= row;
      cur_last <= last_col && last_row;
      dx       <= (col >= cx) ? col - cx : cx - col;
      dy       <= (row >= cy) ? row - cy : cy - row;
      ha       <= span_x[CW-1:1];
      hb       <= span_y[CW-1:1];
      degen    <= (span_x[CW-1:1] == '0) || (span_y[CW-1:1] == '0);
    end
    if (cmd.load_sq) begin
      dx2 <= SQW'(dx) * SQW'(dx);
      dy2 <= SQW'(dy) * SQW'(dy);
      a2  <= HSQW'(ha) * HSQW'(ha);
      b2  <= HSQW'(hb) * HSQW'(hb);
    end
    if (cmd.load_prod) begin
      px <= PW'(dx2) * PW'(b2);
      py <= PW'(dy2) * PW'(a2);
      ab <= ABW'(a2) * ABW'(b2);
    end
  end

  assign ell_sum = SUMW'(px) + SUMW'(py);
  assign in_ell  = !degen && (ell_sum < SUMW'(ab));

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      pixel_value  <= in_ell ? fill_color : BACKGROUND;
      pixel_column <= cur_col;
      pixel_row    <= cur_row;
      frame_last   <= cur_last;
    end
  end

endmodule

`default_nettype wire
